/* sv/dltq_pkg.sv */
// Package: shared types and constants for the delta list timer queue.
package dltq_pkg;

    localparam int unsigned DefaultDepth = 16;
    localparam int unsigned CfgIndexWidth = 1;
    localparam int unsigned CfgDataWidth = 20;

    typedef enum logic [1:0] {
        REQ_ARM    = 2'd0,
        REQ_CANCEL = 2'd1,
        REQ_BEAT   = 2'd2,
        REQ_SECOND = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        RES_ARMED  = 2'd0,
        RES_CANCEL = 2'd1,
        RES_EXPIRY = 2'd2,
        RES_FULL   = 2'd3
    } res_kind_t;

    localparam logic [CfgIndexWidth-1:0] CFG_PERIOD = 1'd0;
    localparam logic [CfgIndexWidth-1:0] CFG_RATE   = 1'd1;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

/* sv/dltq_if.sv */
// Interfaces: request, result and configuration channels.
interface dltq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [31:0] delay_us;
    logic        repeat_flag;
    logic [31:0] user_tag;
    logic [31:0] cancel_ticket;
    modport source (output valid, req_type, delay_us, repeat_flag, user_tag, cancel_ticket,
                    input ready);
    modport sink (input valid, req_type, delay_us, repeat_flag, user_tag, cancel_ticket,
                  output ready);
endinterface

interface dltq_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  result_kind;
    logic [31:0] ticket_out;
    logic [31:0] tag_out;
    logic        found;
    logic        last;
    modport source (output valid, result_kind, ticket_out, tag_out, found, last,
                    input ready);
    modport sink (input valid, result_kind, ticket_out, tag_out, found, last,
                  output ready);
endinterface

interface dltq_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [19:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

/* sv/dltq_div.sv */
// Restoring divider: 32-bit dividend by 20-bit divisor, one quotient bit per cycle.
module dltq_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [31:0]           dividend,
    input  logic [19:0]           divisor,
    output logic [31:0]           quotient,
    output dltq_pkg::div_status_t status
);
    import dltq_pkg::*;

    logic [31:0] quo_reg;
    logic [19:0] rem_reg;
    logic [19:0] dsr_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [20:0] rem_sh;
    logic        take;

    assign rem_sh = {rem_reg, quo_reg[31]};
    assign take   = rem_sh >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                quo_reg  <= dividend;
                rem_reg  <= '0;
                dsr_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                // quotient bits shift in where dividend bits shift out
                rem_reg <= take ? 20'(rem_sh - {1'b0, dsr_reg}) : rem_sh[19:0];
                quo_reg <= {quo_reg[30:0], take};
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

    assert property (@(posedge clk) disable iff (!rst_n) done_reg |-> !busy_reg)
        else $error("divider done while busy");
    assert property (@(posedge clk) disable iff (!rst_n) start |=> busy_reg)
        else $error("divider did not start");
    assert property (@(posedge clk) disable iff (!rst_n) $fell(busy_reg) |-> done_reg)
        else $error("divider stopped without done");
endmodule

/* sv/delta_list_timer_queue.sv */
// Delta list timer queue: channels: req (requests), res (results), cfg (register writes).
// Requests: arm, cancel, heartbeat tick, second mark. One request is taken at a time;
// req.ready is high only while the sequencer is idle.
// Arm: the divider converts microseconds to ticks, then a free-slot scan (one slot a cycle)
// and a walk of the sorted list (one entry a cycle) place the entry before the result is
// registered; an arm on a full list gets a full result instead. Cancel walks the list
// one entry a cycle.
// Tick and second mark remove each entry that falls due, re-insert the periodic ones by
// walking the list again, and then close.
// Each request gives its results in order, the final one flagged with last; a tick or
// second mark with nothing due gives none.
// Results pass through a holding stage and an output register; when the output register
// is full and res.ready is low, the sequencer waits until it is free.
// Reset empties the list, clears ticket and beat counters and loads 1000 into both
// registers. Configuration is written whenever cfg.valid is high.
module delta_list_timer_queue #(
    parameter int unsigned QUEUE_DEPTH = dltq_pkg::DefaultDepth
) (
    input  logic     clk,
    input  logic     rst_n,
    dltq_req_if.sink   req,
    dltq_res_if.source res,
    dltq_cfg_if.sink   cfg
);
    import dltq_pkg::*;

    localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW-1:0] FullCount = CW'(QUEUE_DEPTH);
    localparam logic [IW-1:0] LastSlot = IW'(QUEUE_DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_FIND, S_INS_WALK, S_INS_PUT, S_CAN_WALK, S_ADV, S_REINS, S_FLUSH
    } state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] ticket;
        logic [31:0] tag;
        logic        found;
    } result_t;

    state_t state_reg;

    logic [19:0] period_reg;
    logic [19:0] rate_reg;

    logic [31:0] ent_ticket_reg   [QUEUE_DEPTH];
    logic [31:0] ent_delta_reg    [QUEUE_DEPTH];
    logic [31:0] ent_interval_reg [QUEUE_DEPTH];
    logic [31:0] ent_tag_reg      [QUEUE_DEPTH];
    logic        ent_live_reg     [QUEUE_DEPTH];
    logic        ent_occ_reg      [QUEUE_DEPTH];
    logic [IW-1:0] link_reg       [QUEUE_DEPTH];
    logic [IW-1:0] fired_reg      [QUEUE_DEPTH];

    logic [CW-1:0] count_reg;
    logic [CW-1:0] nf_reg;
    logic [CW-1:0] pos_reg;
    logic [31:0]   next_ticket_reg;
    logic [19:0]   beat_reg;

    logic [IW-1:0] slot_reg;
    logic [31:0]   ins_delta_reg;
    logic          ins_adv_reg;
    logic [19:0]   cnt_reg;
    logic [31:0]   ticks_reg;
    logic          rep_reg;
    logic [31:0]   tag_reg;
    logic [31:0]   ctk_reg;

    logic          pend_valid_reg;
    result_t       pend_reg;
    logic          out_valid_reg;
    result_t       out_reg;
    logic          out_last_reg;

    logic          div_start;
    logic [31:0]   div_q;
    div_status_t   div_st;

    logic          out_free;
    logic          can_post;
    logic [IW-1:0] walk_slot;
    logic [IW-1:0] head_slot;
    logic [31:0]   walk_delta;
    logic [31:0]   head_delta;
    logic [19:0]   cnt_next;
    logic [19:0]   adj;
    logic [IW-1:0] pos_idx;
    logic [IW-1:0] fired_top;

    assign out_free  = !out_valid_reg || res.ready;
    assign can_post  = !pend_valid_reg || out_free;
    assign pos_idx   = pos_reg[IW-1:0];
    assign walk_slot = link_reg[pos_idx];
    assign head_slot = link_reg[0];
    assign walk_delta = ent_delta_reg[walk_slot];
    assign head_delta = ent_delta_reg[head_slot];
    assign cnt_next  = 20'(cnt_reg - head_delta[19:0]);
    assign adj       = (rate_reg > beat_reg) ? 20'(rate_reg - beat_reg) : 20'd0;
    assign fired_top = fired_reg[IW'(nf_reg - CW'(1))];
    assign div_start = req.valid && req.ready && (req.req_type == REQ_ARM)
                       && (count_reg != FullCount);

    dltq_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (req.delay_us),
        .divisor  ((req.valid && period_reg == 20'd0) ? 20'd1 :
                   (period_reg == 20'd0 ? 20'd1 : period_reg)),
        .quotient (div_q),
        .status   (div_st)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            period_reg      <= 20'd1000;
            rate_reg        <= 20'd1000;
            count_reg       <= '0;
            nf_reg          <= '0;
            next_ticket_reg <= '0;
            beat_reg        <= '0;
            pend_valid_reg  <= 1'b0;
            out_valid_reg   <= 1'b0;
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                ent_live_reg[i] <= 1'b0;
                ent_occ_reg[i]  <= 1'b0;
            end
        end
        else
        begin
            if (out_valid_reg && res.ready)
                out_valid_reg <= 1'b0;

            if (cfg.valid)
            begin
                unique case (cfg.index)
                    CFG_PERIOD: period_reg <= cfg.data;
                    CFG_RATE:   rate_reg   <= cfg.data;
                    default:    ;
                endcase
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        rep_reg <= req.repeat_flag;
                        tag_reg <= req.user_tag;
                        ctk_reg <= req.cancel_ticket;
                        pos_reg <= '0;
                        nf_reg  <= '0;
                        unique case (req_kind_t'(req.req_type))
                            REQ_ARM:
                            begin
                                if (count_reg == FullCount)
                                begin
                                    pend_valid_reg <= 1'b1;
                                    pend_reg <= '{kind: RES_FULL, ticket: '0, tag: '0,
                                                  found: 1'b0};
                                    state_reg <= S_FLUSH;
                                end
                                else
                                    state_reg <= S_DIV;
                            end
                            REQ_CANCEL: state_reg <= S_CAN_WALK;
                            REQ_BEAT:
                            begin
                                if (beat_reg != '1)
                                    beat_reg <= beat_reg + 20'd1;
                                cnt_reg   <= 20'd1;
                                state_reg <= S_ADV;
                            end
                            REQ_SECOND:
                            begin
                                beat_reg  <= '0;
                                cnt_reg   <= adj;
                                state_reg <= (adj != '0) ? S_ADV : S_FLUSH;
                            end
                            default: state_reg <= S_IDLE;
                        endcase
                    end
                end

                S_DIV:
                begin
                    if (div_st.done)
                    begin
                        ticks_reg <= (div_q == '0) ? 32'd1 : div_q;
                        slot_reg  <= '0;
                        state_reg <= S_FIND;
                    end
                end

                S_FIND:
                begin
                    if (!ent_occ_reg[slot_reg] || slot_reg == LastSlot)
                    begin
                        next_ticket_reg            <= next_ticket_reg + 32'd1;
                        ent_ticket_reg[slot_reg]   <= next_ticket_reg + 32'd1;
                        ent_tag_reg[slot_reg]      <= tag_reg;
                        ent_interval_reg[slot_reg] <= rep_reg ? ticks_reg : 32'd0;
                        ent_live_reg[slot_reg]     <= 1'b1;
                        ins_delta_reg <= ticks_reg;
                        ins_adv_reg   <= 1'b0;
                        pos_reg       <= '0;
                        state_reg     <= S_INS_WALK;
                    end
                    else
                        slot_reg <= slot_reg + IW'(1);
                end

                S_INS_WALK:
                begin
                    if (pos_reg == count_reg)
                        state_reg <= S_INS_PUT;
                    else if (ins_delta_reg <= walk_delta)
                    begin
                        ent_delta_reg[walk_slot] <= walk_delta - ins_delta_reg;
                        state_reg <= S_INS_PUT;
                    end
                    else
                    begin
                        ins_delta_reg <= ins_delta_reg - walk_delta;
                        pos_reg       <= pos_reg + CW'(1);
                    end
                end

                S_INS_PUT:
                begin
                    for (int i = 1; i < QUEUE_DEPTH; i++)
                        if (CW'(i) > pos_reg)
                            link_reg[i] <= link_reg[i-1];
                    link_reg[pos_idx]       <= slot_reg;
                    ent_delta_reg[slot_reg] <= ins_delta_reg;
                    ent_occ_reg[slot_reg]   <= 1'b1;
                    count_reg <= count_reg + CW'(1);
                    if (ins_adv_reg)
                        state_reg <= S_REINS;
                    else
                    begin
                        pend_valid_reg <= 1'b1;
                        pend_reg <= '{kind: RES_ARMED, ticket: next_ticket_reg, tag: '0,
                                      found: 1'b0};
                        state_reg <= S_FLUSH;
                    end
                end

                S_CAN_WALK:
                begin
                    if (pos_reg == count_reg)
                    begin
                        pend_valid_reg <= 1'b1;
                        pend_reg <= '{kind: RES_CANCEL, ticket: ctk_reg, tag: '0,
                                      found: 1'b0};
                        state_reg <= S_FLUSH;
                    end
                    else if (ent_live_reg[walk_slot] && ent_ticket_reg[walk_slot] == ctk_reg)
                    begin
                        ent_live_reg[walk_slot] <= 1'b0;
                        pend_valid_reg <= 1'b1;
                        pend_reg <= '{kind: RES_CANCEL, ticket: ctk_reg, tag: '0,
                                      found: 1'b1};
                        state_reg <= S_FLUSH;
                    end
                    else
                        pos_reg <= pos_reg + CW'(1);
                end

                S_ADV:
                begin
                    if (count_reg == '0)
                        state_reg <= S_REINS;
                    else if (head_delta > {12'd0, cnt_reg})
                    begin
                        ent_delta_reg[head_slot] <= head_delta - {12'd0, cnt_reg};
                        state_reg <= S_REINS;
                    end
                    else if (!ent_live_reg[head_slot] || can_post)
                    begin
                        cnt_reg <= cnt_next;
                        for (int i = 0; i < QUEUE_DEPTH - 1; i++)
                            link_reg[i] <= link_reg[i+1];
                        count_reg <= count_reg - CW'(1);
                        ent_occ_reg[head_slot] <= 1'b0;
                        if (ent_live_reg[head_slot])
                        begin
                            // the previous result is now known not to be the last one
                            if (pend_valid_reg)
                            begin
                                out_valid_reg <= 1'b1;
                                out_reg       <= pend_reg;
                                out_last_reg  <= 1'b0;
                            end
                            pend_valid_reg <= 1'b1;
                            pend_reg <= '{kind: RES_EXPIRY, ticket: ent_ticket_reg[head_slot],
                                          tag: ent_tag_reg[head_slot], found: 1'b0};
                            if (ent_interval_reg[head_slot] == '0)
                                ent_live_reg[head_slot] <= 1'b0;
                            else
                            begin
                                ent_delta_reg[head_slot] <=
                                    (ent_interval_reg[head_slot] > {12'd0, cnt_next}) ?
                                    ent_interval_reg[head_slot] - {12'd0, cnt_next} : 32'd0;
                                fired_reg[nf_reg[IW-1:0]] <= head_slot;
                                nf_reg <= nf_reg + CW'(1);
                            end
                        end
                    end
                end

                S_REINS:
                begin
                    // re-queue periodic timers, most recent first
                    if (nf_reg == '0)
                        state_reg <= S_FLUSH;
                    else
                    begin
                        nf_reg        <= nf_reg - CW'(1);
                        slot_reg      <= fired_top;
                        ins_delta_reg <= ent_delta_reg[fired_top];
                        ins_adv_reg   <= 1'b1;
                        pos_reg       <= '0;
                        state_reg     <= S_INS_WALK;
                    end
                end

                S_FLUSH:
                begin
                    if (!pend_valid_reg)
                        state_reg <= S_IDLE;
                    else if (out_free)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_reg        <= pend_reg;
                        out_last_reg   <= 1'b1;
                        pend_valid_reg <= 1'b0;
                        state_reg      <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.result_kind = out_reg.kind;
    assign res.ticket_out  = out_reg.ticket;
    assign res.tag_out     = out_reg.tag;
    assign res.found       = out_reg.found;
    assign res.last        = out_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= FullCount)
        else $error("entry count beyond depth");
    assert property (@(posedge clk) disable iff (!rst_n)
                     (state_reg == S_IDLE) |-> !pend_valid_reg)
        else $error("held result left behind at idle");
    assert property (@(posedge clk) disable iff (!rst_n)
                     (state_reg == S_IDLE) |-> (nf_reg == '0 || !div_st.busy))
        else $error("divider busy at idle");
    assert property (@(posedge clk) disable iff (!rst_n)
                     (pend_valid_reg && out_valid_reg && !res.ready) |=> pend_valid_reg)
        else $error("held result lost while output stalled");
endmodule
